FILE: design/cpop_pkg.sv
// shared types and constants of the polynomial circle octant plotter
package cpop_pkg;

    // default centre coordinate width
    localparam int COORD_BITS_DEF = 10;
    // fixed field widths
    localparam int RADIUS_BITS    = 9;
    localparam int COLUMN_BITS    = 10;
    localparam int PIXEL_BITS     = 12;
    localparam int NUM_POINTS     = 8;

    // configuration register indexes
    localparam logic [1:0] CFG_CENTER_X = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [1:0] CFG_RADIUS   = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQRT,
        ST_ROUND,
        ST_EMIT
    } state_t;

endpackage

FILE: design/circle_polynomial_octant_plot_top.sv
// circle plotter top level: column sequencer, digit-serial square root, point emitter
//
// Every accepted input transaction (s_tdata[0] = start_req) plots one column x of one
// octant: the block forms r*r - x*x, takes its square root rounded to nearest in a
// restoring square root that retires one result bit (two radicand bits) per cycle, and
// then sends the eight mirrored points, one output transaction per cycle while m_tready
// is high. A column passes through accepting the transaction, forming the radicand,
// RADIUS_BITS = 9 root steps, a rounding step and eight output transactions. The last
// point of a column may wait in the output register while the next column is already
// being worked on. An advance with no plot in progress, or a start with radius 0, is
// taken and gives no output. m_tlast marks the eighth point of a column and m_tuser is
// set on all points of the final column. Configuration writes are always taken and
// belong to times when no column is being worked on.
module circle_polynomial_octant_plot_top #(
    parameter int COORD_BITS = cpop_pkg::COORD_BITS_DEF,
    localparam int CFG_BITS  = (COORD_BITS > cpop_pkg::RADIUS_BITS) ?
                               COORD_BITS : cpop_pkg::RADIUS_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [0] start_req, [7:1] zero
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,   // [11:0] pixel_x, [23:12] pixel_y
    output logic                m_tlast,   // last_point
    output logic                m_tuser,   // [0] finished
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    localparam int RAD_W   = cpop_pkg::RADIUS_BITS;
    localparam int COL_W   = cpop_pkg::COLUMN_BITS;
    localparam int PIX_W   = cpop_pkg::PIXEL_BITS;
    localparam int SQ_W    = 2 * RAD_W;           // radicand width
    localparam int XX_W    = 2 * COL_W;           // square of the column
    localparam int NXX_W   = XX_W + 1;
    localparam int PREM_W  = RAD_W + 1;           // partial remainder
    localparam int PART_W  = PREM_W + 2;
    localparam int Y_W     = RAD_W + 1;
    localparam int STEP_W  = $clog2(RAD_W);
    localparam int IDX_W   = $clog2(cpop_pkg::NUM_POINTS);
    localparam logic [STEP_W-1:0] LastStep = STEP_W'(RAD_W - 1);
    localparam logic [IDX_W-1:0]  LastIdx  = IDX_W'(cpop_pkg::NUM_POINTS - 1);

    // control state
    cpop_pkg::state_t         state_reg, state_next;
    logic [COORD_BITS-1:0]    cx_reg, cx_next;
    logic [COORD_BITS-1:0]    cy_reg, cy_next;
    logic [RAD_W-1:0]         radius_reg, radius_next;
    logic [COL_W-1:0]         column_reg, column_next;
    logic [XX_W-1:0]          xx_reg, xx_next;
    logic                     active_reg, active_next;
    logic                     valid_reg, valid_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;

    // datapath
    logic [SQ_W-1:0]          rad_sh_reg, rad_sh_next;
    logic [SQ_W-1:0]          rem_reg, rem_next;
    logic [PREM_W-1:0]        prem_reg, prem_next;
    logic [RAD_W-1:0]         root_reg, root_next;
    logic                     fin_reg, fin_next;
    logic [Y_W-1:0]           y_reg, y_next;
    logic [PIX_W-1:0]         px_reg, px_next;
    logic [PIX_W-1:0]         py_reg, py_next;
    logic                     last_reg, last_next;
    logic                     outfin_reg, outfin_next;

    // combinational helpers
    logic                     in_xfer;
    logic                     start_req;
    logic [SQ_W-1:0]          rr;
    logic [PART_W-1:0]        part;
    logic [PART_W-1:0]        trial;
    logic                     ge;
    logic [NXX_W-1:0]         nxx;
    logic [PIX_W-1:0]         cx_w, cy_w, a_w, b_w;
    logic                     load;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == cpop_pkg::ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign start_req = s_tdata[0];

    assign m_tvalid  = valid_reg;
    assign m_tdata   = {py_reg, px_reg};
    assign m_tlast   = last_reg;
    assign m_tuser   = outfin_reg;

    // r*r term of the radicand r*r - x*x, which is clamped at zero when loaded
    assign rr = SQ_W'(radius_reg) * SQ_W'(radius_reg);

    // one restoring square root step: two radicand bits in, one root bit out
    assign part  = {prem_reg, rad_sh_reg[SQ_W-1 -: 2]};
    assign trial = PART_W'({root_reg, 2'b01});
    assign ge    = (part >= trial);

    // (x+1)^2 from x^2
    assign nxx = NXX_W'(xx_reg) + NXX_W'({column_reg, 1'b1});

    // point operands: swap for the second half, negate per quadrant bit
    assign cx_w = PIX_W'(cx_reg);
    assign cy_w = PIX_W'(cy_reg);
    assign a_w  = idx_reg[2] ? PIX_W'(y_reg) : PIX_W'(column_reg);
    assign b_w  = idx_reg[2] ? PIX_W'(column_reg) : PIX_W'(y_reg);

    assign load = !valid_reg || m_tready;

    // configuration register writes
    always_comb begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        radius_next = radius_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                cpop_pkg::CFG_CENTER_X: cx_next     = cfg_data[COORD_BITS-1:0];
                cpop_pkg::CFG_CENTER_Y: cy_next     = cfg_data[COORD_BITS-1:0];
                cpop_pkg::CFG_RADIUS:   radius_next = cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer: next state and datapath loads
    always_comb begin
        state_next  = state_reg;
        column_next = column_reg;
        xx_next     = xx_reg;
        active_next = active_reg;
        valid_next  = valid_reg && !m_tready;
        step_next   = step_reg;
        idx_next    = idx_reg;
        rad_sh_next = rad_sh_reg;
        rem_next    = rem_reg;
        prem_next   = prem_reg;
        root_next   = root_reg;
        fin_next    = fin_reg;
        y_next      = y_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        last_next   = last_reg;
        outfin_next = outfin_reg;

        unique case (state_reg)
            cpop_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (start_req) begin
                        column_next = '0;
                        xx_next     = '0;
                        active_next = (radius_reg != '0);
                        if (radius_reg != '0) begin
                            state_next = cpop_pkg::ST_LOAD;
                        end
                    end else if (active_reg) begin
                        state_next = cpop_pkg::ST_LOAD;
                    end
                end
            end

            cpop_pkg::ST_LOAD: begin
                rem_next    = (SQ_W + 2)'(rr) > (SQ_W + 2)'(xx_reg) ?
                              SQ_W'(rr - SQ_W'(xx_reg)) : '0;
                rad_sh_next = (SQ_W + 2)'(rr) > (SQ_W + 2)'(xx_reg) ?
                              SQ_W'(rr - SQ_W'(xx_reg)) : '0;
                prem_next   = '0;
                root_next   = '0;
                step_next   = '0;
                state_next  = cpop_pkg::ST_SQRT;
            end

            cpop_pkg::ST_SQRT: begin
                prem_next   = ge ? PREM_W'(part - trial) : PREM_W'(part);
                root_next   = {root_reg[RAD_W-2:0], ge};
                rad_sh_next = {rad_sh_reg[SQ_W-3:0], 2'b00};
                fin_next    = !(nxx < NXX_W'(rem_reg));
                step_next   = step_reg + 1'b1;
                if (step_reg == LastStep) begin
                    state_next = cpop_pkg::ST_ROUND;
                end
            end

            cpop_pkg::ST_ROUND: begin
                // round up when the remainder exceeds the floor root
                y_next     = Y_W'(root_reg) +
                             Y_W'(PREM_W'(prem_reg) > PREM_W'(root_reg));
                idx_next   = '0;
                state_next = cpop_pkg::ST_EMIT;
            end

            cpop_pkg::ST_EMIT: begin
                if (load) begin
                    valid_next  = 1'b1;
                    px_next     = idx_reg[0] ? cx_w - a_w : cx_w + a_w;
                    py_next     = idx_reg[1] ? cy_w - b_w : cy_w + b_w;
                    last_next   = (idx_reg == LastIdx);
                    outfin_next = fin_reg;
                    idx_next    = idx_reg + 1'b1;
                    if (idx_reg == LastIdx) begin
                        state_next = cpop_pkg::ST_IDLE;
                        if (fin_reg) begin
                            active_next = 1'b0;
                            column_next = '0;
                            xx_next     = '0;
                        end else begin
                            column_next = column_reg + 1'b1;
                            xx_next     = XX_W'(nxx);
                        end
                    end
                end
            end

            default: state_next = cpop_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= cpop_pkg::ST_IDLE;
            cx_reg     <= '0;
            cy_reg     <= '0;
            radius_reg <= '0;
            column_reg <= '0;
            xx_reg     <= '0;
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            step_reg   <= '0;
            idx_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            radius_reg <= radius_next;
            column_reg <= column_next;
            xx_reg     <= xx_next;
            active_reg <= active_next;
            valid_reg  <= valid_next;
            step_reg   <= step_next;
            idx_reg    <= idx_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        rad_sh_reg <= rad_sh_next;
        rem_reg    <= rem_next;
        prem_reg   <= prem_next;
        root_reg   <= root_next;
        fin_reg    <= fin_next;
        y_reg      <= y_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        last_reg   <= last_next;
        outfin_reg <= outfin_next;
    end

    // a column is only worked on while a plot is in progress
    a_busy_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != cpop_pkg::ST_IDLE) |-> active_reg)
        else $error("column sequencer busy without a plot in progress");

    // no plot in progress means the column walk is back at zero
    a_idle_column: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (column_reg == '0 && xx_reg == '0))
        else $error("column state not cleared outside a plot");

    // the running square of the column tracks the column
    a_square_track: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (xx_reg == XX_W'(column_reg) * XX_W'(column_reg)))
        else $error("running column square out of step");

    // the root iteration never runs past its last step
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cpop_pkg::ST_SQRT) |-> (step_reg <= LastStep))
        else $error("square root step count out of range");

endmodule

FILE: tb/sv/testbench.sv
// testbench for the polynomial circle octant plotter: column predictor and pixel checker
`timescale 1ns / 100ps

module testbench;

    localparam int CFG_W        = (cpop_pkg::COORD_BITS_DEF > cpop_pkg::RADIUS_BITS) ?
                                  cpop_pkg::COORD_BITS_DEF : cpop_pkg::RADIUS_BITS;
    localparam int ITEMS_TOTAL  = 200;
    localparam int SETTLE_CYC   = 40;
    localparam int HOLD_CYC     = 400;
    localparam int LIMIT_CYC    = 300000;
    localparam int MAX_PRINTS   = 30;

    // one plotted pixel as it leaves the block
    typedef struct packed {
        logic [cpop_pkg::PIXEL_BITS-1:0] px;
        logic [cpop_pkg::PIXEL_BITS-1:0] py;
        logic                            last;
        logic                            fin;
    } pixel_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = 8'd0;   // [0] start_req, [7:1] zero
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [23:0]      m_tdata;            // [11:0] pixel_x, [23:12] pixel_y
    logic             m_tlast;            // last_point
    logic             m_tuser;            // [0] finished
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = cpop_pkg::CFG_CENTER_X;
    logic [CFG_W-1:0] cfg_data  = '0;

    // start flags waiting to be offered, and pixels still owed by the block
    logic   start_q[$];
    pixel_t pixel_q[$];
    bit     offering   = 1'b0;
    bit     steady_run = 1'b0;
    bit     hold_go    = 1'b0;
    int     hold_left  = 0;

    // predicted register and plot state
    logic [cpop_pkg::COORD_BITS_DEF-1:0] center_x = '0;
    logic [cpop_pkg::COORD_BITS_DEF-1:0] center_y = '0;
    logic [cpop_pkg::RADIUS_BITS-1:0]    radius   = '0;
    logic [cpop_pkg::COLUMN_BITS-1:0]    col_x    = '0;
    bit                                  plotting = 1'b0;

    int cols_done  = 0;
    int items_in   = 0;
    int pixels_ok  = 0;
    int reg_writes = 0;
    int errors     = 0;
    int cycles     = 0;

    circle_polynomial_octant_plot_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        if (errors < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    // works out the eight mirrored pixels of one column and queues them
    function automatic void plot_column(input logic start_req);
        int unsigned r, x, y, rem, nx, trial;
        logic                            fin;
        logic [cpop_pkg::PIXEL_BITS-1:0] xs, ys, cxs, cys;
        if (start_req) begin
            col_x    = '0;
            plotting = (radius != 0);
        end
        if (!plotting)
            return;
        r   = radius;
        x   = col_x;
        rem = (r * r > x * x) ? r * r - x * x : 0;
        // exact floor root, then round half up
        y = 0;
        for (int b = cpop_pkg::RADIUS_BITS; b >= 0; b--) begin
            trial = y | (32'd1 << b);
            if (trial * trial <= rem)
                y = trial;
        end
        if (rem > y * y + y)
            y++;
        nx  = x + 1;
        fin = !(nx * nx < rem);
        xs  = cpop_pkg::PIXEL_BITS'(x);
        ys  = cpop_pkg::PIXEL_BITS'(y);
        cxs = cpop_pkg::PIXEL_BITS'(center_x);
        cys = cpop_pkg::PIXEL_BITS'(center_y);
        pixel_q.push_back('{cxs + xs, cys + ys, 1'b0, fin});
        pixel_q.push_back('{cxs - xs, cys + ys, 1'b0, fin});
        pixel_q.push_back('{cxs + xs, cys - ys, 1'b0, fin});
        pixel_q.push_back('{cxs - xs, cys - ys, 1'b0, fin});
        pixel_q.push_back('{cxs + ys, cys + xs, 1'b0, fin});
        pixel_q.push_back('{cxs - ys, cys + xs, 1'b0, fin});
        pixel_q.push_back('{cxs + ys, cys - xs, 1'b0, fin});
        pixel_q.push_back('{cxs - ys, cys - xs, 1'b1, fin});
        if (fin) begin
            plotting = 1'b0;
            col_x    = '0;
        end else begin
            col_x = cpop_pkg::COLUMN_BITS'(nx);
        end
        cols_done++;
    endfunction

    // input driver: offers queued start flags, idles at random
    always @(posedge aclk) begin : drive_proc
        logic       nxt_valid;
        logic [7:0] nxt_data;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'd0;
            offering = 1'b0;
        end else begin
            nxt_valid = s_tvalid;
            nxt_data  = s_tdata;
            if (s_tvalid && s_tready) begin
                plot_column(s_tdata[0]);
                items_in++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && start_q.size() != 0 &&
                (steady_run || $urandom_range(0, 99) >= 15)) begin
                nxt_data  = {7'd0, start_q.pop_front()};
                nxt_valid = 1'b1;
            end
            offering = nxt_valid;
            s_tvalid <= nxt_valid;
            s_tdata  <= nxt_data;
        end
    end

    // result receiver: random back-pressure plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_go) begin
                hold_left = HOLD_CYC;
                hold_go   = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady_run || ($urandom_range(0, 99) >= 15);
            end
        end
    end

    // monitor: each output transaction against the oldest predicted pixel
    always @(posedge aclk) begin : check_proc
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pixel_q.size() == 0) begin
                report_mismatch($sformatf("pixel (%0d,%0d) with none expected",
                                          m_tdata[11:0], m_tdata[23:12]));
            end else begin
                want = pixel_q.pop_front();
                if (m_tdata[11:0] !== want.px)
                    report_mismatch($sformatf("pixel_x %h, expected %h", m_tdata[11:0], want.px));
                if (m_tdata[23:12] !== want.py)
                    report_mismatch($sformatf("pixel_y %h, expected %h", m_tdata[23:12], want.py));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last_point %b, expected %b", m_tlast, want.last));
                if (m_tuser !== want.fin)
                    report_mismatch($sformatf("finished %b, expected %b", m_tuser, want.fin));
                pixels_ok++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYC) begin
            $display("timeout with %0d pixels outstanding", pixel_q.size());
            $display("[circle_polynomial_octant_plot_top] ERROR");
            $finish;
        end
    end

    // register write; valid stays high until the caller lowers it
    task automatic set_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            cpop_pkg::CFG_CENTER_X: center_x = val[cpop_pkg::COORD_BITS_DEF-1:0];
            cpop_pkg::CFG_CENTER_Y: center_y = val[cpop_pkg::COORD_BITS_DEF-1:0];
            cpop_pkg::CFG_RADIUS:   radius   = val[cpop_pkg::RADIUS_BITS-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_circle(input int cx, input int cy, input int rdata);
        set_reg(cpop_pkg::CFG_CENTER_X, CFG_W'(cx));
        set_reg(cpop_pkg::CFG_CENTER_Y, CFG_W'(cy));
        set_reg(cpop_pkg::CFG_RADIUS, CFG_W'(rdata));
        cfg_valid <= 1'b0;
    endtask

    // waits until every pixel is in, then waits out the SETTLE_CYC settle period
    task automatic settle();
        do @(posedge aclk); while (start_q.size() != 0 || offering || pixel_q.size() != 0);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    function automatic int pick_center();
        int sel;
        sel = $urandom_range(0, 9);
        return (sel == 0) ? 0 : (sel == 1) ? 1023 : $urandom_range(0, 1023);
    endfunction

    initial begin : stim_proc
        int goal, n, sel, rpick;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle advance, then a start with zero radius: no pixels
        start_q.push_back(1'b0);
        start_q.push_back(1'b1);
        start_q.push_back(1'b0);
        settle();

        // largest radius at the far corner, upper radius bit dropped; coordinates wrap
        set_circle(1023, 0, 10'h3FF);
        start_q.push_back(1'b1);
        repeat (3) start_q.push_back(1'b0);
        settle();

        // radius shrunk under a running plot: remainder clamps to zero, column ends it
        set_reg(cpop_pkg::CFG_RADIUS, CFG_W'(2));
        cfg_valid <= 1'b0;
        start_q.push_back(1'b0);
        start_q.push_back(1'b0);
        settle();

        // radius one: single final column
        set_circle(0, 1023, 1);
        start_q.push_back(1'b1);
        settle();

        // small full plot, then restarts in the middle of one
        set_reg(cpop_pkg::CFG_RADIUS, CFG_W'(3));
        cfg_valid <= 1'b0;
        start_q.push_back(1'b1);
        start_q.push_back(1'b0);
        start_q.push_back(1'b0);
        start_q.push_back(1'b0);
        start_q.push_back(1'b1);
        start_q.push_back(1'b0);
        start_q.push_back(1'b1);
        settle();

        // long output hold-off while columns keep coming
        set_circle(512, 341, 400);
        hold_go = 1'b1;
        start_q.push_back(1'b1);
        repeat (9) start_q.push_back(1'b0);
        settle();

        // random plots: mostly a start followed by advances, some noise
        goal = ITEMS_TOTAL;
        n    = 0;
        while (items_in < goal) begin
            n++;
            steady_run = (n >= 6 && n < 10);
            if ($urandom_range(0, 4) != 0) begin
                if ($urandom_range(0, 2) != 0)
                    set_reg(cpop_pkg::CFG_CENTER_X, CFG_W'(pick_center()));
                if ($urandom_range(0, 2) != 0)
                    set_reg(cpop_pkg::CFG_CENTER_Y, CFG_W'(pick_center()));
                sel   = $urandom_range(0, 19);
                rpick = (sel < 2) ? 0 : (sel < 17) ? $urandom_range(1, 40)
                                                   : $urandom_range(41, 511);
                set_reg(cpop_pkg::CFG_RADIUS,
                        {1'($urandom_range(0, 1)), cpop_pkg::RADIUS_BITS'(rpick)});
                cfg_valid <= 1'b0;
            end
            if ($urandom_range(0, 4) != 0)
                start_q.push_back(1'b1);
            repeat ($urandom_range(1, 24))
                start_q.push_back($urandom_range(0, 99) < 5);
            settle();
        end
        steady_run = 1'b0;

        $display("%0d input transactions, %0d columns plotted, %0d pixels compared",
                 items_in, cols_done, pixels_ok);
        $display("covered radius 0 to 511, centers at both edges, wrap, restarts and a long stall");
        if (errors == 0) begin
            $display("[circle_polynomial_octant_plot_top] OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("[circle_polynomial_octant_plot_top] ERROR");
        end
        $finish;
    end

endmodule
